// ===== src/urxf_pkg.sv =====
// Shared types and constants for the UART receiver with receive FIFO.
package urxf_pkg;

    // Width of the bit period register and of the tick counter.
    localparam int TICK_W = 16;
    // Width of one received byte.
    localparam int DATA_W = 8;
    // Width of the fill count result field.
    localparam int FILL_W = 11;
    // Reset value of the bit period register.
    localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd104;
    // Default receive FIFO depth.
    localparam int FIFO_DEPTH_DEF = 1024;
    // Index of the last data bit of a frame.
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Receiver frame phases.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HALF = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } rx_phase_t;

    // One classified tick, handed from the receiver to the FIFO side.
    typedef struct packed {
        logic              pop;
        logic              have_byte;
        logic [DATA_W-1:0] data;
        logic              ferr;
        logic              busy;
    } rx_event_t;

endpackage

// ===== src/urxf_rx_front.sv =====
// Receiver front end: samples the line each tick and classifies frame events.
module urxf_rx_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [urxf_pkg::TICK_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      rx_level,
    input  logic                      pop_request,
    input  logic                      queue_full,
    output logic                      push_valid,
    output urxf_pkg::rx_event_t       push_event
);
    import urxf_pkg::*;

    logic [TICK_W-1:0] bit_ticks_reg;
    rx_phase_t         phase_reg, phase_next;
    logic [TICK_W-1:0] tick_counter_reg, tick_counter_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [DATA_W-1:0] shift_byte_reg, shift_byte_next;

    logic              accept;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] target;
    logic              wait_end;

    // A tick is taken whenever the queue has room.
    assign in_stall   = queue_full;
    assign accept     = in_valid && !queue_full;
    assign push_valid = accept;

    // Wait counter: one add, a compare against the current target and a wrap check.
    always_comb
    begin
        tick_inc = tick_counter_reg + 1'b1;
        target   = (phase_reg == PH_HALF) ? (bit_ticks_reg >> 1) : bit_ticks_reg;
        wait_end = (tick_inc >= target) || (tick_inc == '0);
    end

    // Next phase of the frame.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!rx_level)
                    phase_next = PH_HALF;
            end
            PH_HALF:
            begin
                if (wait_end)
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (wait_end && (bit_index_reg == LAST_BIT))
                    phase_next = PH_STOP;
            end
            PH_STOP:
            begin
                if (wait_end)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Counter, bit index and shift register updates.
    always_comb
    begin
        tick_counter_next = tick_counter_reg;
        bit_index_next    = bit_index_reg;
        shift_byte_next   = shift_byte_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!rx_level)
                begin
                    tick_counter_next = '0;
                    bit_index_next    = '0;
                    shift_byte_next   = '0;
                end
            end
            PH_DATA:
            begin
                tick_counter_next = wait_end ? '0 : tick_inc;
                if (wait_end)
                begin
                    shift_byte_next[bit_index_reg] = rx_level;
                    bit_index_next = bit_index_reg + 1'b1;
                end
            end
            default:
            begin
                tick_counter_next = wait_end ? '0 : tick_inc;
            end
        endcase
    end

    // Event handed to the FIFO side for this tick.
    always_comb
    begin
        push_event.pop       = pop_request;
        push_event.have_byte = (phase_reg == PH_STOP) && wait_end && rx_level;
        push_event.ferr      = (phase_reg == PH_STOP) && wait_end && !rx_level;
        push_event.data      = shift_byte_reg;
        push_event.busy      = (phase_next != PH_IDLE);
    end

    // Receiver state advances on each accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_counter_reg <= '0;
            bit_index_reg    <= '0;
            shift_byte_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            tick_counter_reg <= tick_counter_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
        end
    end

    // Bit period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_ticks_reg <= BIT_TICKS_RESET;
        else if (cfg_write)
            bit_ticks_reg <= cfg_data;
    end

endmodule

// ===== src/urxf_queue.sv =====
// Two entry queue that decouples the receiver from the FIFO side.
module urxf_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  urxf_pkg::rx_event_t push_event,
    output logic                full,
    output logic                head_valid,
    output urxf_pkg::rx_event_t head_event,
    input  logic                pop
);
    import urxf_pkg::*;

    rx_event_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_event = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_event;
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/urxf_fifo_back.sv =====
// FIFO side: applies pops and pushes to the byte store and forms each result.
module urxf_fifo_back
#(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        event_valid,
    input  urxf_pkg::rx_event_t         event_in,
    output logic                        event_take,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [urxf_pkg::DATA_W-1:0] head_byte,
    output logic [urxf_pkg::FILL_W-1:0] fill_count,
    output logic                        pop_done,
    output logic                        byte_stored,
    output logic                        framing_error,
    output logic                        overflow,
    output logic                        rx_busy
);
    import urxf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    logic [DATA_W-1:0] store_mem [FIFO_DEPTH];

    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] rdata_reg;
    logic              bypass_reg;
    logic [DATA_W-1:0] bypass_byte_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] head_byte_reg;
    logic [FILL_W-1:0] fill_count_reg;
    logic              pop_done_reg;
    logic              byte_stored_reg;
    logic              framing_error_reg;
    logic              overflow_reg;
    logic              rx_busy_reg;

    logic              step;
    logic              do_pop;
    logic              do_push;
    logic              do_ovf;
    logic [CW-1:0]     count_after_pop;
    logic [DATA_W-1:0] head_now;
    logic [CW+FILL_W-1:0] count_wide;

    // An event is carried out when the result register is free or draining.
    assign step       = event_valid && (!out_valid_reg || !out_stall);
    assign event_take = step;

    // Pop before push; the head comes from the store or from a same-cycle write.
    always_comb
    begin
        head_now        = (count_reg != '0)
                          ? (bypass_reg ? bypass_byte_reg : rdata_reg) : '0;
        do_pop          = event_in.pop && (count_reg != '0);
        count_after_pop = do_pop ? (count_reg - 1'b1) : count_reg;
        do_push         = event_in.have_byte && (count_after_pop != FULL_CNT);
        do_ovf          = event_in.have_byte && (count_after_pop == FULL_CNT);
        count_next      = do_push ? (count_after_pop + 1'b1) : count_after_pop;
        rd_ptr_next     = rd_ptr_reg;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + 1'b1);
        wr_ptr_next     = wr_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + 1'b1);
        count_wide      = {{FILL_W{1'b0}}, count_next};
    end

    // Byte store: one write and one registered read of the next head.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (do_push)
                store_mem[wr_ptr_reg] <= event_in.data;
            rdata_reg       <= store_mem[rd_ptr_next];
            bypass_byte_reg <= event_in.data;
        end
    end

    // Pointers, count and the write-to-head bypass flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else if (step)
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            bypass_reg <= do_push && (rd_ptr_next == wr_ptr_reg);
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            head_byte_reg     <= head_now;
            fill_count_reg    <= count_wide[FILL_W-1:0];
            pop_done_reg      <= do_pop;
            byte_stored_reg   <= do_push;
            framing_error_reg <= event_in.ferr;
            overflow_reg      <= do_ovf;
            rx_busy_reg       <= event_in.busy;
        end
    end

    assign out_valid     = out_valid_reg;
    assign head_byte     = head_byte_reg;
    assign fill_count    = fill_count_reg;
    assign pop_done      = pop_done_reg;
    assign byte_stored   = byte_stored_reg;
    assign framing_error = framing_error_reg;
    assign overflow      = overflow_reg;
    assign rx_busy       = rx_busy_reg;

endmodule

// ===== src/uart_receiver_with_fifo.sv =====
// An accepted tick passes through the event queue and then the result register.
// Throughput: one tick per cycle unless stalled; the receiver and FIFO store take one each.
// The FIFO store has one write and one registered read port, so the head is prefetched.
// Reset clears the receiver, the pointers, the count and the queue at once; the store
// itself is not cleared and needs no clearing pass.
module uart_receiver_with_fifo
#(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [urxf_pkg::TICK_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          rx_level,
    input  logic                          pop_request,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [urxf_pkg::DATA_W-1:0]   head_byte,
    output logic [urxf_pkg::FILL_W-1:0]   fill_count,
    output logic                          pop_done,
    output logic                          byte_stored,
    output logic                          framing_error,
    output logic                          overflow,
    output logic                          rx_busy
);
    import urxf_pkg::*;

    logic      push_valid;
    rx_event_t push_event;
    logic      queue_full;
    logic      head_valid;
    rx_event_t head_event;
    logic      event_take;

    // Receiver front end.
    urxf_rx_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_level    (rx_level),
        .pop_request (pop_request),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_event  (push_event)
    );

    // Event queue between the two sides.
    urxf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_event (push_event),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_event (head_event),
        .pop        (event_take)
    );

    // FIFO side and result register.
    urxf_fifo_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .event_valid   (head_valid),
        .event_in      (head_event),
        .event_take    (event_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .head_byte     (head_byte),
        .fill_count    (fill_count),
        .pop_done      (pop_done),
        .byte_stored   (byte_stored),
        .framing_error (framing_error),
        .overflow      (overflow),
        .rx_busy       (rx_busy)
    );

endmodule
